// ===== rtl/lsb_first_bit_packer_top_macros.svh =====
// lsb_first_bit_packer_top_macros.svh: assertion macros for the bit packer checker
// needs clk and rst_n in the scope of the module that uses them
`ifndef LSB_FIRST_BIT_PACKER_TOP_MACROS_SVH
`define LSB_FIRST_BIT_PACKER_TOP_MACROS_SVH

// same-cycle implication, quiet during reset
`define LBP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, quiet during reset
`define LBP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/lbp_pkg.sv =====
// lbp_pkg: widths and transaction types of the lsb-first bit packer
// no dependencies; used by the interfaces and all packer modules
package lbp_pkg;

  localparam int FIELD_VALUE_W = 32;
  localparam int FIELD_WIDTH_W = 6;
  localparam int BYTE_W        = 8;
  localparam int OUT_COUNT_W   = 16;
  localparam int LEFTOVER_W    = 7;
  localparam int POS_W         = 3;

  typedef struct packed {
    logic [FIELD_VALUE_W-1:0] field_value;
    logic [FIELD_WIDTH_W-1:0] field_width;
    logic                     end_message;
  } in_item_t;

  typedef struct packed {
    logic [BYTE_W-1:0]      data_byte;
    logic                   last_of_run;
    logic                   message_done;
    logic [OUT_COUNT_W-1:0] bytes_so_far;
    logic                   width_error;
  } out_item_t;

endpackage

// ===== rtl/lbp_if.sv =====
// lbp_if: valid/ready channel interfaces for the bit packer input and result streams
// depends on lbp_pkg for field widths
interface lbp_in_if;
  logic                                valid;
  logic                                ready;
  logic [lbp_pkg::FIELD_VALUE_W-1:0]   field_value;
  logic [lbp_pkg::FIELD_WIDTH_W-1:0]   field_width;
  logic                                end_message;

  modport source (output valid, field_value, field_width, end_message, input ready);
  modport sink   (input valid, field_value, field_width, end_message, output ready);
endinterface

interface lbp_out_if;
  logic                              valid;
  logic                              ready;
  logic [lbp_pkg::BYTE_W-1:0]        data_byte;
  logic                              last_of_run;
  logic                              message_done;
  logic [lbp_pkg::OUT_COUNT_W-1:0]   bytes_so_far;
  logic                              width_error;

  modport source (output valid, data_byte, last_of_run, message_done, bytes_so_far,
                  width_error, input ready);
  modport sink   (input valid, data_byte, last_of_run, message_done, bytes_so_far,
                  width_error, output ready);
endinterface

// ===== rtl/lsb_first_bit_packer_top.sv =====
// lsb_first_bit_packer_top: packs 0 to MAX_FIELD_BITS bit fields, lsb first, into bytes
// depends on lbp_pkg, lbp_if, lbp_in_stage, lbp_pack, lbp_out_stage
//
//  channel | dir | payload (valid/ready handshake on both)
//  --------+-----+-------------------------------------------------------------------------
//  in_ch   | in  | field_value[31:0] field_width[5:0] end_message
//  out_ch  | out | data_byte[7:0] last_of_run message_done bytes_so_far[15:0] width_error
//
// one result transaction per cycle while the output register has room; an input transaction
// holds the byte emitter until all its results (none to five at the default width) are emitted
// first result passes the input register, the emitter and the output register in turn
// synchronous active-low reset clears leftover bits, bit position and message byte count
// input register and output register each part the two sides, so a stalled result still
// lets the next input transaction in
module lsb_first_bit_packer_top #(
  parameter int MAX_FIELD_BITS = 32,
  parameter int COUNT_BITS     = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  lbp_in_if.sink    in_ch,
  lbp_out_if.source out_ch
);

  // input register to packer
  logic               item_valid;
  logic               item_take;
  lbp_pkg::in_item_t  item;

  // packer to output register
  logic               res_valid;
  logic               res_free;
  lbp_pkg::out_item_t res;

  lbp_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .item_valid (item_valid),
    .item       (item),
    .item_take  (item_take)
  );

  // merge with leftover bits, then one byte per cycle while the output register has room
  lbp_pack #(
    .MAX_FIELD_BITS (MAX_FIELD_BITS),
    .COUNT_BITS     (COUNT_BITS)
  ) u_pack (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (item_valid),
    .item       (item),
    .item_take  (item_take),
    .res_valid  (res_valid),
    .res        (res),
    .res_free   (res_free)
  );

  lbp_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res       (res),
    .res_free  (res_free),
    .out_ch    (out_ch)
  );

endmodule

// ===== rtl/lbp_in_stage.sv =====
// lbp_in_stage: input register of the bit packer
// depends on lbp_pkg and lbp_in_if
module lbp_in_stage (
  input  logic              clk,
  input  logic              rst_n,
  lbp_in_if.sink            in_ch,
  output logic              item_valid,
  output lbp_pkg::in_item_t item,
  input  logic              item_take
);

  logic              valid_r;
  lbp_pkg::in_item_t item_r;

  assign in_ch.ready = !valid_r || item_take;
  assign item_valid  = valid_r;
  assign item        = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ch.valid && in_ch.ready) begin
      valid_r <= 1'b1;
    end else if (item_take) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      item_r.field_value <= in_ch.field_value;
      item_r.field_width <= in_ch.field_width;
      item_r.end_message <= in_ch.end_message;
    end
  end

endmodule

// ===== rtl/lbp_pack.sv =====
// lbp_pack: merges a field with the leftover bits and emits the bytes one per cycle while res_free is high
// depends on lbp_pkg
module lbp_pack #(
  parameter int MAX_FIELD_BITS = 32,
  parameter int COUNT_BITS     = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               item_valid,
  input  lbp_pkg::in_item_t  item,
  output logic               item_take,
  output logic               res_valid,
  output lbp_pkg::out_item_t res,
  input  logic               res_free
);

  localparam int W     = MAX_FIELD_BITS + lbp_pkg::LEFTOVER_W;
  localparam int TOT_W = $clog2(W + 1);
  localparam int NB_W  = TOT_W - lbp_pkg::POS_W;
  localparam int NRES  = (MAX_FIELD_BITS + 7) / 8 + 1;
  localparam int RES_W = $clog2(NRES + 1);

  logic [lbp_pkg::LEFTOVER_W-1:0] lo_bits_r;
  logic [lbp_pkg::POS_W-1:0]      lo_cnt_r;
  logic [COUNT_BITS-1:0]          msg_cnt_r, msg_cnt_nxt, cnt_inc;
  logic [W-1:0]                   buf_r;
  logic [RES_W-1:0]               left_r;
  logic                           end_r, err_r;

  logic                           fld_err, flush, emit, ld_ok, last;
  logic [W-1:0]                   fmask, fbits, acc, shifted;
  logic [TOT_W-1:0]               total;
  logic [NB_W-1:0]                nb_full;
  logic [lbp_pkg::POS_W-1:0]      rem;
  logic [RES_W-1:0]               nres;

  // field merge
  always_comb begin
    fld_err = int'(item.field_width) > MAX_FIELD_BITS;
    fmask   = (W'(1) << item.field_width) - W'(1);
    fbits   = W'(item.field_value) & fmask;
    acc     = W'(lo_bits_r) | (fbits << lo_cnt_r);
    total   = TOT_W'(lo_cnt_r) + TOT_W'(item.field_width);
    nb_full = total[TOT_W-1:lbp_pkg::POS_W];
    rem     = total[lbp_pkg::POS_W-1:0];
    flush   = item.end_message && (rem != '0);
    nres    = fld_err ? RES_W'(1) : RES_W'(nb_full) + RES_W'(flush);
    shifted = acc >> {nb_full, 3'b000};
  end

  // emitter handshake
  assign res_valid = (left_r != '0);
  assign emit      = res_valid && res_free;
  assign last      = (left_r == RES_W'(1));
  assign ld_ok     = (left_r == '0) || (last && emit);
  assign item_take = item_valid && ld_ok;
  assign cnt_inc   = (msg_cnt_r == '1) ? msg_cnt_r : msg_cnt_r + COUNT_BITS'(1);

  always_comb begin
    res.data_byte    = err_r ? '0 : buf_r[lbp_pkg::BYTE_W-1:0];
    res.last_of_run  = last;
    res.message_done = last && end_r;
    res.bytes_so_far = err_r ? lbp_pkg::OUT_COUNT_W'(msg_cnt_r)
                             : lbp_pkg::OUT_COUNT_W'(cnt_inc);
    res.width_error  = err_r;
  end

  always_comb begin
    msg_cnt_nxt = msg_cnt_r;
    if (emit && !err_r) begin
      msg_cnt_nxt = (last && end_r) ? '0 : cnt_inc;
    end
    // end of message with nothing to emit
    if (item_take && !fld_err && item.end_message && (nres == '0)) begin
      msg_cnt_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lo_bits_r <= '0;
      lo_cnt_r  <= '0;
      msg_cnt_r <= '0;
      left_r    <= '0;
    end else begin
      msg_cnt_r <= msg_cnt_nxt;
      if (item_take && !fld_err) begin
        lo_bits_r <= item.end_message ? '0 : shifted[lbp_pkg::LEFTOVER_W-1:0];
        lo_cnt_r  <= item.end_message ? '0 : rem;
      end
      if (item_take) begin
        left_r <= nres;
      end else if (emit) begin
        left_r <= left_r - RES_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (item_take) begin
      buf_r <= acc;
      end_r <= item.end_message && !fld_err;
      err_r <= fld_err;
    end else if (emit) begin
      buf_r <= buf_r >> lbp_pkg::BYTE_W;
    end
  end

endmodule

// ===== rtl/lbp_out_stage.sv =====
// lbp_out_stage: result register of the bit packer
// depends on lbp_pkg and lbp_out_if
module lbp_out_stage (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               res_valid,
  input  lbp_pkg::out_item_t res,
  output logic               res_free,
  lbp_out_if.source          out_ch
);

  logic               valid_r;
  lbp_pkg::out_item_t res_r;

  assign res_free            = !valid_r || out_ch.ready;
  assign out_ch.valid        = valid_r;
  assign out_ch.data_byte    = res_r.data_byte;
  assign out_ch.last_of_run  = res_r.last_of_run;
  assign out_ch.message_done = res_r.message_done;
  assign out_ch.bytes_so_far = res_r.bytes_so_far;
  assign out_ch.width_error  = res_r.width_error;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (res_valid && res_free) begin
      valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_free) begin
      res_r <= res;
    end
  end

endmodule

// ===== rtl/lbp_checker.sv =====
// lbp_checker: port-level assertions for the bit packer, bound to the top level
// depends on lsb_first_bit_packer_top_macros.svh and lsb_first_bit_packer_top
`include "lsb_first_bit_packer_top_macros.svh"

module lbp_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [7:0]  out_data_byte,
  input logic        out_last_of_run,
  input logic        out_message_done,
  input logic [15:0] out_bytes_so_far,
  input logic        out_width_error
);

  logic        stalled;
  logic        err_seen;
  logic        err_ok;
  logic        done_seen;
  logic        done_ok;
  logic [26:0] payload;

  assign stalled   = out_valid && !out_ready;
  assign payload   = {out_data_byte, out_last_of_run, out_message_done, out_bytes_so_far,
                      out_width_error};
  assign err_seen  = out_valid && out_width_error;
  assign err_ok    = out_last_of_run && !out_message_done && (out_data_byte == 8'd0);
  assign done_seen = out_valid && out_message_done;
  assign done_ok   = out_last_of_run && !out_width_error;

  `LBP_ASSERT_NEXT(a_out_hold, stalled, out_valid && $stable(payload), "stalled result changed")

  `LBP_ASSERT_NOW(a_err_shape, err_seen, err_ok, "malformed width error result")

  `LBP_ASSERT_NOW(a_done_last, done_seen, done_ok, "message end not on last result")

  `LBP_ASSERT_NOW(a_reset_idle, $past(!rst_n), !out_valid, "result valid straight after reset")

endmodule

bind lsb_first_bit_packer_top lbp_checker u_lbp_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .out_data_byte    (out_ch.data_byte),
  .out_last_of_run  (out_ch.last_of_run),
  .out_message_done (out_ch.message_done),
  .out_bytes_so_far (out_ch.bytes_so_far),
  .out_width_error  (out_ch.width_error)
);

// ===== tb/sv/lbp_tb_pkg.sv =====
// lbp_tb_pkg: expected-byte tracker for the lsb-first bit packer testbench
// depends on lbp_pkg for the transaction types
package lbp_tb_pkg;
  import lbp_pkg::*;

  localparam int          PACK_MAX_FIELD = 32;
  localparam logic [15:0] COUNT_CEIL     = 16'hFFFF;

  class packed_byte_tracker;
    out_item_t   expected_bytes[$];
    logic [6:0]  pend_bits;
    logic [2:0]  pend_count;
    logic [15:0] msg_count;
    int          mismatches;

    function new();
      pend_bits  = '0;
      pend_count = '0;
      msg_count  = '0;
      mismatches = 0;
    endfunction

    function int pending();
      return expected_bytes.size();
    endfunction

    // appends one expected result at the tail
    function void queue_result(out_item_t r);
      expected_bytes.insert(expected_bytes.size(), r);
    endfunction

    task report_mismatch(string what);
      mismatches++;
      $display("[%0t] mismatch: %s", $time, what);
    endtask

    // works out the bytes one accepted field makes and queues them
    function void note_field(in_item_t it);
      out_item_t  run[5];
      out_item_t  r;
      logic [7:0] acc;
      int         cnt;
      int         n;
      int         i;
      n = 0;
      r = '0;
      if (int'(it.field_width) > PACK_MAX_FIELD) begin
        // rejected width: state untouched, end flag ignored
        r.last_of_run  = 1'b1;
        r.bytes_so_far = msg_count;
        r.width_error  = 1'b1;
        queue_result(r);
        return;
      end
      acc = {1'b0, pend_bits};
      cnt = int'(pend_count);
      for (i = 0; i < int'(it.field_width); i++) begin
        acc = acc | (8'(it.field_value[i]) << cnt);
        cnt++;
        if (cnt == 8) begin
          if (msg_count != COUNT_CEIL) msg_count++;
          r = '0;
          r.data_byte    = acc;
          r.bytes_so_far = msg_count;
          run[n] = r;
          n++;
          acc = '0;
          cnt = 0;
        end
      end
      if (it.end_message) begin
        if (cnt > 0) begin
          if (msg_count != COUNT_CEIL) msg_count++;
          r = '0;
          r.data_byte    = acc;
          r.message_done = 1'b1;
          r.bytes_so_far = msg_count;
          run[n] = r;
          n++;
        end else if (n > 0) begin
          run[n-1].message_done = 1'b1;
        end
        acc       = '0;
        cnt       = 0;
        msg_count = '0;
      end
      if (n > 0) run[n-1].last_of_run = 1'b1;
      pend_bits  = acc[6:0];
      pend_count = 3'(cnt);
      for (i = 0; i < n; i++) queue_result(run[i]);
    endfunction

    task check_byte(out_item_t got);
      out_item_t want;
      if (expected_bytes.size() == 0) begin
        report_mismatch($sformatf("byte %02h with nothing expected", got.data_byte));
        return;
      end
      want = expected_bytes.pop_front();
      if (got.data_byte !== want.data_byte)
        report_mismatch($sformatf("data_byte %02h, want %02h", got.data_byte, want.data_byte));
      if (got.last_of_run !== want.last_of_run)
        report_mismatch($sformatf("last_of_run %b, want %b", got.last_of_run,
                                  want.last_of_run));
      if (got.message_done !== want.message_done)
        report_mismatch($sformatf("message_done %b, want %b", got.message_done,
                                  want.message_done));
      if (got.bytes_so_far !== want.bytes_so_far)
        report_mismatch($sformatf("bytes_so_far %0d, want %0d", got.bytes_so_far,
                                  want.bytes_so_far));
      if (got.width_error !== want.width_error)
        report_mismatch($sformatf("width_error %b, want %b", got.width_error,
                                  want.width_error));
    endtask
  endclass

endpackage

// ===== tb/sv/lsb_first_bit_packer_top_test.sv =====
// lsb_first_bit_packer_top_test: directed and random runs of the bit packer
// depends on lbp_pkg, lbp_if, lbp_tb_pkg and the lsb_first_bit_packer_top rtl
module lsb_first_bit_packer_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  import lbp_pkg::*;
  import lbp_tb_pkg::*;

  // generous limit for the watchdog
  localparam int CYCLE_LIMIT     = 1_000_000;
  // quiet cycles after the last byte
  localparam int SETTLE_CYCLES   = 20;
  localparam int FIELDS_PER_MODE = 20;

  logic clk;
  logic rst_n;
  int   cycles    = 0;
  int   idle_pct  = 0;   // chance per cycle that the sender holds back
  int   stall_pct = 0;   // chance per cycle that the receiver drops ready
  packed_byte_tracker tracker;

  lbp_in_if  in_ch ();
  lbp_out_if out_ch ();

  lsb_first_bit_packer_top dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // watchdog
  initial begin
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  // result side: check each accepted transaction, then pick next cycle's ready
  initial begin
    out_item_t got;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready) begin
        got.data_byte    = out_ch.data_byte;
        got.last_of_run  = out_ch.last_of_run;
        got.message_done = out_ch.message_done;
        got.bytes_so_far = out_ch.bytes_so_far;
        got.width_error  = out_ch.width_error;
        tracker.check_byte(got);
      end
      out_ch.ready <= ($urandom_range(99, 0) >= stall_pct);
    end
  end

  // offers one field and returns on the edge that takes it; the idle gap comes first
  // so valid is only ever lowered or raised once per time step
  task automatic send_field(input logic [31:0] value, input logic [5:0] width,
                            input logic end_msg);
    in_item_t it;
    it.field_value = value;
    it.field_width = width;
    it.end_message = end_msg;
    while ($urandom_range(99, 0) < idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.field_value <= value;
    in_ch.field_width <= width;
    in_ch.end_message <= end_msg;
    do @(posedge clk); while (!in_ch.ready);
    tracker.note_field(it);
  endtask

  initial begin
    int          mode;
    int          sent;
    int          nfields;
    int          k;
    int          pick;
    logic [31:0] value;
    logic [5:0]  width;
    logic        last;
    tracker = new();
    rst_n             <= 1'b0;
    in_ch.valid       <= 1'b0;
    in_ch.field_value <= '0;
    in_ch.field_width <= '0;
    in_ch.end_message <= 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // directed part, no idling
    send_field(32'hFFFF_FFFF, 6'd0,  1'b0);  // zero width without end: nothing
    send_field(32'h0000_0000, 6'd0,  1'b1);  // end on an empty message: nothing
    send_field(32'h0000_0001, 6'd1,  1'b0);
    send_field(32'hFFFF_FFFF, 6'd0,  1'b1);  // end flushes the lone pending bit, padded
    send_field(32'hFFFF_FFFF, 6'd32, 1'b0);  // widest field, all ones
    send_field(32'h0000_0000, 6'd32, 1'b1);  // widest field ending on a byte boundary
    send_field(32'h0000_0005, 6'd3,  1'b0);
    send_field(32'hFFFF_FFFF, 6'd5,  1'b0);  // completes a byte across two fields
    send_field(32'h0000_007F, 6'd7,  1'b0);  // seven bits left over
    send_field(32'hDEAD_BEEF, 6'd33, 1'b1);  // just over the limit, end ignored
    send_field(32'h0000_0000, 6'd63, 1'b0);  // largest width code
    send_field(32'hAAAA_AAAA, 6'd32, 1'b1);  // four full bytes plus a padded fifth
    send_field(32'h0000_00A5, 6'd8,  1'b1);  // single byte closing its message
    send_field(32'h0000_1234, 6'd16, 1'b0);
    send_field(32'h0000_0000, 6'd0,  1'b1);  // end with no partial byte clears the count
    send_field(32'h0000_003C, 6'd8,  1'b0);  // count restarts at one
    send_field(32'h8000_0001, 6'd32, 1'b0);  // top and bottom value bits
    send_field(32'h0000_0001, 6'd1,  1'b0);
    send_field(32'h7FFF_FFFF, 6'd31, 1'b0);  // one pending plus 31 lands on a boundary
    send_field(32'h0000_0000, 6'd40, 1'b1);  // error with no bits pending
    send_field(32'h0000_0015, 6'd5,  1'b1);
    send_field(32'h0000_0006, 6'd3,  1'b1);

    // random messages: a few fields then an end, with errors, empty fields and
    // the odd message that never ends or ends early
    for (mode = 0; mode < 4; mode++) begin
      case (mode)
        0: begin
          idle_pct  = 0;
          stall_pct = 0;
        end
        1: begin
          idle_pct  = 85;
          stall_pct = 0;
        end
        2: begin
          idle_pct  = 0;
          stall_pct = 85;
        end
        default: begin
          idle_pct  = 33;
          stall_pct = 33;
        end
      endcase
      sent = 0;
      while (sent < FIELDS_PER_MODE) begin
        nfields = $urandom_range(6, 1);
        for (k = 0; k < nfields; k++) begin
          pick  = $urandom_range(99, 0);
          value = $urandom();
          if (pick < 6) width = 6'($urandom_range(63, 33));
          else if (pick < 14) width = '0;
          else if (pick < 30) width = 6'(8 * $urandom_range(4, 1));
          else width = 6'($urandom_range(32, 1));
          if (k == nfields - 1) last = ($urandom_range(9, 0) != 0);
          else last = ($urandom_range(19, 0) == 0);
          send_field(value, width, last);
          sent++;
        end
      end
      if (mode == 1) begin
        // sender holds off until every queued byte has been taken
        in_ch.valid <= 1'b0;
        do @(posedge clk); while (tracker.pending() != 0);
      end
    end

    in_ch.valid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (tracker.mismatches == 0 && tracker.pending() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/lbp_pkg.sv
rtl/lbp_if.sv
rtl/lbp_in_stage.sv
rtl/lbp_pack.sv
rtl/lbp_out_stage.sv
rtl/lsb_first_bit_packer_top.sv
rtl/lbp_checker.sv
tb/sv/lbp_tb_pkg.sv
tb/sv/lsb_first_bit_packer_top_test.sv
